[rtl/core/csvm_pkg.sv]
// Package with shared constants for the cube-to-sphere vertex mapper.
package csvm_pkg;

  localparam int unsigned IDX_W = 8;
  localparam int unsigned FACE_W = 3;
  localparam int unsigned OUT_W = 23;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SUBDIV = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'd1;

  // Face codes.
  localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
  localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd1;
  localparam logic [FACE_W-1:0] FACE_BACK   = 3'd2;
  localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd3;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

endpackage

[rtl/core/csvm_if.sv]
// Valid/ready stream interfaces for the vertex mapper input and output.
interface csvm_in_if;
  logic                         valid;
  logic                         ready;
  logic [csvm_pkg::FACE_W-1:0]  face;
  logic [csvm_pkg::IDX_W-1:0]   row_index;
  logic [csvm_pkg::IDX_W-1:0]   col_index;
  modport source (output valid, face, row_index, col_index, input ready);
  modport sink (input valid, face, row_index, col_index, output ready);
endinterface

interface csvm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [csvm_pkg::OUT_W-1:0]  pos_x;
  logic signed [csvm_pkg::OUT_W-1:0]  pos_y;
  logic signed [csvm_pkg::OUT_W-1:0]  pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

[rtl/core/cube_sphere_vertex_map_unit.sv]
// Cube-to-sphere vertex mapper: pipelined grid-to-sphere point mapping.
// Throughput: one transaction per cycle when not stalled; the depth is set by the restoring
// divider (one quotient bit a stage) and the bit-serial square root (one root bit a stage).
// The whole pipeline advances together; a stall at the output holds every stage.
// Reset clears valid bits and loads subdivisions 20 and radius 5.
module cube_sphere_vertex_map_unit #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [csvm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [csvm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  csvm_in_if.sink                              in_if,
  csvm_out_if.source                           out_if
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned QW  = F + 1;          // magnitude of a Q1.F value
  localparam int unsigned NUMW = 9 + F;         // |2k-s| << F
  localparam int unsigned DS  = QW;             // divider stages
  localparam int unsigned SW  = 2 * QW;         // product of two squares
  localparam int unsigned RW  = F + 2;          // radicand width
  localparam int unsigned RTW = F + 2;          // root width
  localparam int unsigned RS  = RTW;            // root stages
  localparam int unsigned RADW = 2 * RTW + 2;   // sqrt remainder width
  localparam int unsigned VW  = 2 * F + 2;      // radicand << F
  localparam int unsigned NST = DS + 6 + RS + 3;
  localparam logic [QW-1:0] ONE = QW'(1) << F;
  localparam int unsigned FACE_W_L = csvm_pkg::FACE_W;

  // Pipeline advance, shared by all stages.
  logic adv;
  logic [NST-1:0] vld_q;
  assign adv = !vld_q[NST-1] || out_if.ready;
  assign in_if.ready = adv;

  // Configuration registers.
  logic [7:0] subdiv_q, radius_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subdiv_q <= 8'd20;
      radius_q <= 8'd5;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == csvm_pkg::REG_SUBDIV) subdiv_q <= cfg_data_i;
      if (cfg_idx_i == csvm_pkg::REG_RADIUS) radius_q <= cfg_data_i;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[NST-2:0], in_if.valid};
  end

  // Stage 0: clamp indices and form |2k - s| with sign.
  logic [7:0] s_eff;
  logic [8:0] ki, kj, ni, nj;
  logic [FACE_W_L-1:0] face0_q;
  logic [8:0] ni0_q, nj0_q;
  logic si0_q, sj0_q;
  logic [7:0] s0_q;
  always_comb begin
    s_eff = (subdiv_q == 8'd0) ? 8'd1 : subdiv_q;
    ki = {1'b0, (in_if.row_index > s_eff) ? s_eff : in_if.row_index};
    kj = {1'b0, (in_if.col_index > s_eff) ? s_eff : in_if.col_index};
    ni = (ki << 1) - {1'b0, s_eff};
    nj = (kj << 1) - {1'b0, s_eff};
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      face0_q <= in_if.face;
      s0_q    <= s_eff;
      si0_q   <= ni[8];
      sj0_q   <= nj[8];
      ni0_q   <= ni[8] ? (~ni + 9'd1) : ni;
      nj0_q   <= nj[8] ? (~nj + 9'd1) : nj;
    end
  end

  // Restoring dividers, one quotient bit per stage, both coordinates in parallel.
  logic [NUMW-1:0] rmi_q [DS+1], rmj_q [DS+1];
  logic [QW-1:0]   qi_q [DS+1], qj_q [DS+1];
  logic [7:0]      ds_q [DS+1];
  logic            dsi_q [DS+1], dsj_q [DS+1];
  logic [FACE_W_L-1:0] dface_q [DS+1];
  always_comb begin
    rmi_q[0] = NUMW'(ni0_q) << F;
    rmj_q[0] = NUMW'(nj0_q) << F;
    qi_q[0] = '0;
    qj_q[0] = '0;
    ds_q[0] = s0_q;
    dsi_q[0] = si0_q;
    dsj_q[0] = sj0_q;
    dface_q[0] = face0_q;
  end
  for (genvar g = 0; g < DS; g++) begin : g_div
    localparam int unsigned SH = DS - 1 - g;
    logic [NUMW+QW-1:0] ti, tj;
    logic ge_i, ge_j;
    always_comb begin
      ti = (NUMW+QW)'(ds_q[g]) << SH;
      tj = ti;
      ge_i = (NUMW+QW)'(rmi_q[g]) >= ti;
      ge_j = (NUMW+QW)'(rmj_q[g]) >= tj;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rmi_q[g+1] <= ge_i ? NUMW'((NUMW+QW)'(rmi_q[g]) - ti) : rmi_q[g];
        rmj_q[g+1] <= ge_j ? NUMW'((NUMW+QW)'(rmj_q[g]) - tj) : rmj_q[g];
        qi_q[g+1]  <= qi_q[g] | (ge_i ? (QW'(1) << SH) : '0);
        qj_q[g+1]  <= qj_q[g] | (ge_j ? (QW'(1) << SH) : '0);
        ds_q[g+1]  <= ds_q[g];
        dsi_q[g+1] <= dsi_q[g];
        dsj_q[g+1] <= dsj_q[g];
        dface_q[g+1] <= dface_q[g];
      end
    end
  end

  // Face placement: magnitudes and signs of x, y, z.
  logic [QW-1:0] mx, my, mz;
  logic sx, sy, sz, zr;
  logic [QW-1:0] ui, uj;
  logic si, sj;
  always_comb begin
    ui = qi_q[DS]; uj = qj_q[DS];
    si = dsi_q[DS] && (ui != '0);
    sj = dsj_q[DS] && (uj != '0);
    mx = '0; my = '0; mz = '0; sx = 1'b0; sy = 1'b0; sz = 1'b0; zr = 1'b0;
    case (dface_q[DS])
      csvm_pkg::FACE_FRONT: begin
        mx = ui; sx = si; my = uj; sy = sj; mz = ONE;
      end
      csvm_pkg::FACE_LEFT: begin
        mx = ONE; sx = 1'b1; my = uj; sy = sj; mz = ui; sz = si;
      end
      csvm_pkg::FACE_BACK: begin
        mx = ui; sx = !si && (ui != '0); my = uj; sy = sj; mz = ONE; sz = 1'b1;
      end
      csvm_pkg::FACE_RIGHT: begin
        mx = ONE; my = uj; sy = sj; mz = ui; sz = si;
      end
      csvm_pkg::FACE_TOP: begin
        mx = ui; sx = !si && (ui != '0); my = ONE; mz = uj; sz = sj;
      end
      csvm_pkg::FACE_BOTTOM: begin
        mx = ui; sx = !si && (ui != '0); my = ONE; sy = 1'b1; mz = uj; sz = sj;
      end
      default: zr = 1'b1;
    endcase
  end

  // Stage A: register placed coordinates.
  logic [QW-1:0] ma_q [3];
  logic [2:0] sa_q;
  logic za_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ma_q[0] <= mx; ma_q[1] <= my; ma_q[2] <= mz;
      sa_q <= {sz, sy, sx};
      za_q <= zr;
    end
  end

  // Stage B: squares, floored to F fraction bits.
  logic [QW-1:0] m2_q [3];
  logic [QW-1:0] mb_q [3];
  logic [2:0] sb_q;
  logic zb_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        m2_q[c] <= QW'(((2*QW)'(ma_q[c]) * (2*QW)'(ma_q[c])) >> F);
        mb_q[c] <= ma_q[c];
      end
      sb_q <= sa_q;
      zb_q <= za_q;
    end
  end

  // Stage C: pairwise products and half sums of squares (index c pairs the other two).
  logic [SW-1:0] pr_q [3];
  logic [QW-1:0] hsum_q [3];
  logic [QW-1:0] mc_q [3];
  logic [2:0] sc_q;
  logic zc_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q[0] <= SW'(m2_q[1]) * SW'(m2_q[2]);
      pr_q[1] <= SW'(m2_q[2]) * SW'(m2_q[0]);
      pr_q[2] <= SW'(m2_q[0]) * SW'(m2_q[1]);
      hsum_q[0] <= QW'(m2_q[1] >> 1) + QW'(m2_q[2] >> 1);
      hsum_q[1] <= QW'(m2_q[2] >> 1) + QW'(m2_q[0] >> 1);
      hsum_q[2] <= QW'(m2_q[0] >> 1) + QW'(m2_q[1] >> 1);
      mc_q <= mb_q;
      sc_q <= sb_q;
      zc_q <= zb_q;
    end
  end

  // Stage D: floor(p / (3 << F)) by shift then a reciprocal multiply for the divide by three.
  // p >> F is at most 2^F; floor(floor(p/2^F)/3) equals floor(p/(3*2^F)), and
  // multiplying by ceil(2^(F+3)/3) then shifting by F+3 is exact in that range.
  localparam int unsigned RK = F + 3;
  localparam int unsigned PW = QW + RK;
  localparam int unsigned RECIP3 = ((1 << RK) + 2) / 3;
  logic [QW-1:0] t3_q [3];
  logic [QW-1:0] hd_q [3];
  logic [QW-1:0] md_q [3];
  logic [2:0] sd_q;
  logic zd_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        t3_q[c] <= QW'((PW'(pr_q[c] >> F) * PW'(RECIP3)) >> RK);
        hd_q[c] <= hsum_q[c];
        md_q[c] <= mc_q[c];
      end
      sd_q <= sc_q;
      zd_q <= zc_q;
    end
  end

  // Stage E: radicand, clamped at zero.
  logic [RW-1:0] rad_q [3];
  logic [QW-1:0] me_q [3];
  logic [2:0] se_q;
  logic ze_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        logic signed [RW+1:0] r;
        r = (RW+2)'(ONE) - (RW+2)'(hd_q[c]) + (RW+2)'(t3_q[c]);
        rad_q[c] <= r[RW+1] ? '0 : RW'(r);
        me_q[c] <= md_q[c];
      end
      se_q <= sd_q;
      ze_q <= zd_q;
    end
  end

  // Bit-serial square roots of rad << F, one root bit per stage.
  logic [VW-1:0]   sv_q [3][RS+1];
  logic [RADW-1:0] sr_q [3][RS+1];
  logic [RTW-1:0]  rt_q [3][RS+1];
  logic [QW-1:0]   sm_q [3][RS+1];
  logic [2:0]      ss_q [RS+1];
  logic            sz_q [RS+1];
  for (genvar c = 0; c < 3; c++) begin : g_sqrt_in
    always_comb begin
      sv_q[c][0] = VW'(rad_q[c]) << F;
      sr_q[c][0] = '0;
      rt_q[c][0] = '0;
      sm_q[c][0] = me_q[c];
    end
  end
  always_comb begin
    ss_q[0] = se_q;
    sz_q[0] = ze_q;
  end
  for (genvar g = 0; g < RS; g++) begin : g_sqrt
    localparam int unsigned PB = 2 * (RS - 1 - g);
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [RADW-1:0] rem, trial;
      logic [1:0] pair;
      always_comb begin
        pair  = (PB + 1 < VW) ? 2'(sv_q[c][g] >> PB) : {1'b0, 1'(sv_q[c][g] >> PB)};
        rem   = {sr_q[c][g][RADW-3:0], pair};
        trial = {(RADW-2)'(rt_q[c][g]), 2'b01};
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          sv_q[c][g+1] <= sv_q[c][g];
          sm_q[c][g+1] <= sm_q[c][g];
          if (rem >= trial) begin
            sr_q[c][g+1] <= rem - trial;
            rt_q[c][g+1] <= {rt_q[c][g][RTW-2:0], 1'b1};
          end else begin
            sr_q[c][g+1] <= rem;
            rt_q[c][g+1] <= {rt_q[c][g][RTW-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ss_q[g+1] <= ss_q[g];
        sz_q[g+1] <= sz_q[g];
      end
    end
  end

  // Stage F: |c| * root, floored.
  logic [QW:0] mg_q [3];
  logic [2:0] sf_q;
  logic zf_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++)
        mg_q[c] <= (QW+1)'(((QW+RTW)'(sm_q[c][RS]) * (QW+RTW)'(rt_q[c][RS])) >> F);
      sf_q <= ss_q[RS];
      zf_q <= sz_q[RS];
    end
  end

  // Stage G: radius scaling.
  logic [QW+8:0] mr_q [3];
  logic [2:0] sg_q;
  logic zg_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++)
        mr_q[c] <= (QW+9)'(mg_q[c]) * (QW+9)'(radius_q);
      sg_q <= sf_q;
      zg_q <= zf_q;
    end
  end

  // Stage H: sign, truncation to the output width and output register.
  logic [csvm_pkg::OUT_W-1:0] px_q, py_q, pz_q;
  function automatic logic [csvm_pkg::OUT_W-1:0] fin(input logic [QW+8:0] m,
                                                     input logic s, input logic z);
    logic [csvm_pkg::OUT_W-1:0] t;
    begin
      t = csvm_pkg::OUT_W'(m);
      if (z) fin = '0;
      else fin = s ? (~t + 1'b1) : t;
    end
  endfunction
  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= fin(mr_q[0], sg_q[0], zg_q);
      py_q <= fin(mr_q[1], sg_q[1], zg_q);
      pz_q <= fin(mr_q[2], sg_q[2], zg_q);
    end
  end

  assign out_if.valid = vld_q[NST-1];
  assign out_if.pos_x = px_q;
  assign out_if.pos_y = py_q;
  assign out_if.pos_z = pz_q;

endmodule

[dv/csvm_tb_if.sv]
// Testbench-side note: the channel interfaces come from the RTL; this file holds the shared tb types.
package csvm_tb_pkg;

  // One mapped vertex position.
  typedef struct packed {
    logic signed [csvm_pkg::OUT_W-1:0] x;
    logic signed [csvm_pkg::OUT_W-1:0] y;
    logic signed [csvm_pkg::OUT_W-1:0] z;
  } vertex_t;
endpackage

[dv/csvm_checker.sv]
// Checker that predicts each mapped vertex and compares it with the block output.
module csvm_checker #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [csvm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [csvm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  csvm_in_if.sink     in_mon,
  csvm_out_if.sink    out_mon,
  output int          err_cnt_o,
  output int          pending_o
);

  localparam longint ONE = longint'(1) << FRAC_BITS;

  logic [7:0] subdiv_q;
  logic [7:0] radius_q;
  csvm_tb_pkg::vertex_t expected_q[$];

  // Face coordinate 2k/s-1, truncated toward zero.
  function automatic longint grid_coord(int unsigned k, int unsigned s);
    longint num;
    longint q;
    if (s == 0) s = 1;
    if (k > s) k = s;
    num = 2 * longint'(k) - longint'(s);
    q = ((num < 0 ? -num : num) << FRAC_BITS) / longint'(s);
    return num < 0 ? -q : q;
  endfunction

  function automatic longint sq_frac(longint a);
    longint m;
    m = a < 0 ? -a : a;
    return (m * m) >> FRAC_BITS;
  endfunction

  // Floor square root by bisection.
  function automatic longint floor_sqrt(longint v);
    longint lo;
    longint hi;
    longint mid;
    lo = 0;
    hi = 32'hFFFF_FFFF;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic signed [csvm_pkg::OUT_W-1:0] sphere_coord(longint c, longint a2,
                                                                     longint b2);
    longint r;
    longint mag;
    r = ONE - (a2 >> 1) - (b2 >> 1) + (a2 * b2) / (3 * ONE);
    if (r < 0) r = 0;
    mag = (((c < 0 ? -c : c) * floor_sqrt(r << FRAC_BITS)) >> FRAC_BITS) * radius_q;
    return csvm_pkg::OUT_W'(c < 0 ? -mag : mag);
  endfunction

  function automatic csvm_tb_pkg::vertex_t map_vertex(logic [csvm_pkg::FACE_W-1:0] face,
                                                      logic [7:0] i, logic [7:0] j);
    longint ui;
    longint uj;
    longint x;
    longint y;
    longint z;
    csvm_tb_pkg::vertex_t v;
    ui = grid_coord(i, subdiv_q);
    uj = grid_coord(j, subdiv_q);
    v = '0;
    case (face)
      csvm_pkg::FACE_FRONT: begin x = ui; y = uj; z = ONE; end
      csvm_pkg::FACE_LEFT: begin x = -ONE; y = uj; z = ui; end
      csvm_pkg::FACE_BACK: begin x = -ui; y = uj; z = -ONE; end
      csvm_pkg::FACE_RIGHT: begin x = ONE; y = uj; z = ui; end
      csvm_pkg::FACE_TOP: begin x = -ui; y = ONE; z = uj; end
      csvm_pkg::FACE_BOTTOM: begin x = -ui; y = -ONE; z = uj; end
      default: return v;
    endcase
    v.x = sphere_coord(x, sq_frac(y), sq_frac(z));
    v.y = sphere_coord(y, sq_frac(z), sq_frac(x));
    v.z = sphere_coord(z, sq_frac(x), sq_frac(y));
    return v;
  endfunction

  // Track configuration, predict on input transactions, compare on output transactions.
  always @(posedge clk_i or negedge rst_ni) begin
    csvm_tb_pkg::vertex_t got;
    csvm_tb_pkg::vertex_t exp_v;
    if (!rst_ni) begin
      subdiv_q <= 8'd20;
      radius_q <= 8'd5;
      err_cnt_o <= 0;
      pending_o <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == csvm_pkg::REG_SUBDIV) subdiv_q <= cfg_data_i;
        else if (cfg_idx_i == csvm_pkg::REG_RADIUS) radius_q <= cfg_data_i;
      end
      if (in_mon.valid && in_mon.ready)
        expected_q = {expected_q,
                      map_vertex(in_mon.face, in_mon.row_index, in_mon.col_index)};
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.pos_x, out_mon.pos_y, out_mon.pos_z};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, got.x, got.y, got.z);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_v = expected_q.pop_front();
          if (got.x !== exp_v.x || got.y !== exp_v.y || got.z !== exp_v.z) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d actual x=%0d y=%0d z=%0d",
                     $time, exp_v.x, exp_v.y, exp_v.z, got.x, got.y, got.z);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      pending_o <= expected_q.size();
    end
  end
endmodule

[dv/tb_top.sv]
// Top-level testbench: stimulus, configuration phases and verdict for the vertex mapper.
module tb_top;

  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [csvm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [csvm_pkg::CFG_DATA_W-1:0] cfg_data_i;
  int   err_cnt;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   idle_cycles;

  csvm_in_if  in_ch();
  csvm_out_if out_ch();

  cube_sphere_vertex_map_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  csvm_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // Receiver stalls at random per phase.
  always @(negedge clk_i)
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [csvm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Send one vertex request, holding it until accepted.
  task automatic send_point(logic [csvm_pkg::FACE_W-1:0] f, logic [7:0] i, logic [7:0] j);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.face <= f;
    in_ch.row_index <= i;
    in_ch.col_index <= j;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Wait for all results, then let the pipeline settle before a register write.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_run(int n, int sub_max);
    int k;
    int s;
    for (k = 0; k < n; k++) begin
      s = sub_max + 2;
      if ($urandom_range(3) == 0) send_point(3'($urandom), 8'($urandom), 8'($urandom));
      else send_point(3'($urandom_range(5)), 8'($urandom_range(s)), 8'($urandom_range(s)));
    end
  endtask

  initial begin
    int f;
    int ph;
    logic [7:0] subs[6];
    logic [7:0] rads[6];
    subs = '{8'd20, 8'd1, 8'd255, 8'd0, 8'd7, 8'd128};
    rads = '{8'd5, 8'd255, 8'd1, 8'd0, 8'd170, 8'd85};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = csvm_pkg::REG_SUBDIV;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.face = '0;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every face code at a grid corner and an edge midpoint, clamped indices, unused faces.
    for (f = 0; f < 8; f++) begin
      send_point(f[2:0], 8'd0, 8'd0);
      send_point(f[2:0], 8'd10, 8'd20);
    end
    send_point(csvm_pkg::FACE_FRONT, 8'd255, 8'd255);
    send_point(csvm_pkg::FACE_TOP, 8'd21, 8'd170);
    send_point(csvm_pkg::FACE_BOTTOM, 8'd85, 8'd3);

    // Sender holds off until everything has come back.
    drain();

    // Random phases over register settings, sender idle and receiver stall patterns.
    for (ph = 0; ph < 6; ph++) begin
      write_reg(csvm_pkg::REG_SUBDIV, subs[ph]);
      write_reg(csvm_pkg::REG_RADIUS, rads[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 52; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 52; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      random_run(72, (subs[ph] == 0) ? 1 : subs[ph]);
      drain();
    end

    if (err_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
